@@ rtl/erpt_pkg.sv @@
// Shared types, state encodings and register indexes for the rigid point transform.
package erpt_pkg;

	typedef logic signed [17:0] entry_t;
	typedef entry_t [8:0] mat_t;

	localparam int unsigned NUM_ENTRIES = 9;
	localparam int unsigned NUM_PRODS = 14;

	localparam logic [2:0] REG_ANGLE_X = 3'd0;
	localparam logic [2:0] REG_ANGLE_Y = 3'd1;
	localparam logic [2:0] REG_ANGLE_Z = 3'd2;
	localparam logic [2:0] REG_SHIFT_X = 3'd3;
	localparam logic [2:0] REG_SHIFT_Y = 3'd4;
	localparam logic [2:0] REG_SHIFT_Z = 3'd5;

	localparam entry_t ENTRY_ONE = 18'sd65536;

	typedef enum logic [2:0] {
		SC_IDLE,
		SC_SQUARE,
		SC_MUL,
		SC_DIV_START,
		SC_DIV_WAIT,
		SC_SIN_MUL,
		SC_FINISH
	} sc_state_t;

	typedef enum logic [2:0] {
		ROT_IDLE,
		ROT_SC_START,
		ROT_SC_WAIT,
		ROT_PROD,
		ROT_COMBINE
	} rot_state_t;

endpackage

@@ rtl/erpt_div.sv @@
// Constant divider by reciprocal multiplication: 33-bit dividend by an even divisor up to 182.
module erpt_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [32:0] dividend,
	input  logic [7:0]  divisor,
	output logic        done,
	output logic [32:0] quotient
);
	// magic = ceil(2^41 / d); exact floor(n / d) for every n below 2^33 and d below 256
	localparam logic [63:0] P41 = 64'd1 << 41;
	localparam logic [40:0] M_2   = 41'((P41 + 64'd1) / 64'd2);
	localparam logic [40:0] M_6   = 41'((P41 + 64'd5) / 64'd6);
	localparam logic [40:0] M_12  = 41'((P41 + 64'd11) / 64'd12);
	localparam logic [40:0] M_20  = 41'((P41 + 64'd19) / 64'd20);
	localparam logic [40:0] M_30  = 41'((P41 + 64'd29) / 64'd30);
	localparam logic [40:0] M_42  = 41'((P41 + 64'd41) / 64'd42);
	localparam logic [40:0] M_56  = 41'((P41 + 64'd55) / 64'd56);
	localparam logic [40:0] M_72  = 41'((P41 + 64'd71) / 64'd72);
	localparam logic [40:0] M_90  = 41'((P41 + 64'd89) / 64'd90);
	localparam logic [40:0] M_110 = 41'((P41 + 64'd109) / 64'd110);
	localparam logic [40:0] M_132 = 41'((P41 + 64'd131) / 64'd132);
	localparam logic [40:0] M_156 = 41'((P41 + 64'd155) / 64'd156);
	localparam logic [40:0] M_182 = 41'((P41 + 64'd181) / 64'd182);

	logic [40:0] magic;
	logic [32:0] dvd_s1;
	logic [40:0] mag_s1;
	logic [53:0] lo_s2;
	logic [32:0] quo_q;
	logic        vld_s1;
	logic        vld_s2;
	logic        done_q;
	logic [52:0] hi_p;
	logic [73:0] full;

	always_comb begin
		unique case (divisor)
			8'd2:    magic = M_2;
			8'd6:    magic = M_6;
			8'd12:   magic = M_12;
			8'd20:   magic = M_20;
			8'd30:   magic = M_30;
			8'd42:   magic = M_42;
			8'd56:   magic = M_56;
			8'd72:   magic = M_72;
			8'd90:   magic = M_90;
			8'd110:  magic = M_110;
			8'd132:  magic = M_132;
			8'd156:  magic = M_156;
			8'd182:  magic = M_182;
			default: magic = '0;
		endcase
	end

	// upper partial product joins the registered lower one
	always_comb begin
		hi_p = 53'(dvd_s1) * 53'(mag_s1[40:21]);
		full = 74'(lo_s2) + {hi_p, 21'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			done_q <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
			done_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_s1 <= dividend;
			mag_s1 <= magic;
		end
		if (vld_s1) begin
			lo_s2 <= 54'(dvd_s1) * 54'(mag_s1[20:0]);
		end
		if (vld_s2) begin
			quo_q <= full[73:41];
		end
	end

	assign done = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/erpt_sincos.sv @@
// Sequenced sine and cosine of a Q2.13 angle by a Horner Taylor series.
module erpt_sincos (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [15:0]   angle,
	output logic                 done,
	output erpt_pkg::entry_t     sin_val,
	output erpt_pkg::entry_t     cos_val
);
	import erpt_pkg::*;

	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	localparam logic signed [34:0] PI_Q30 = 35'sd3373259426;
	localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

	function automatic logic [7:0] horner_div(logic cos_phase, logic [2:0] step);
		logic [7:0] d;
		d = 8'd2;
		if (!cos_phase) begin
			unique case (step)
				3'd0: d = 8'd156;
				3'd1: d = 8'd110;
				3'd2: d = 8'd72;
				3'd3: d = 8'd42;
				3'd4: d = 8'd20;
				default: d = 8'd6;
			endcase
		end else begin
			unique case (step)
				3'd0: d = 8'd182;
				3'd1: d = 8'd132;
				3'd2: d = 8'd90;
				3'd3: d = 8'd56;
				3'd4: d = 8'd30;
				3'd5: d = 8'd12;
				default: d = 8'd2;
			endcase
		end
		return d;
	endfunction

	sc_state_t state_q, state_d;

	logic [30:0] ar_q;
	logic        neg_q;
	logic        rneg_q;
	logic [31:0] r2_q;
	logic [30:0] t_q;
	logic [30:0] sm_q;
	logic [32:0] num_q;
	logic [2:0]  step_q;
	logic        cos_q;
	logic        done_q;
	entry_t      sin_q;
	entry_t      cos_val_q;

	logic signed [34:0] r_raw;
	logic signed [34:0] r_fold;
	logic               fold_neg;
	logic               r_neg;
	logic [30:0]        r_abs;
	logic [31:0]        mul_a;
	logic [30:0]        mul_b;
	logic [62:0]        mul_p;
	logic               div_done;
	logic [32:0]        div_quo;
	logic               last_step;
	logic [31:0]        sm_rnd;
	logic [31:0]        cm_rnd;
	logic [16:0]        sv_mag;
	logic [16:0]        cv_mag;

	// fold by pi into the convergent range
	always_comb begin
		r_raw = 35'(angle) <<< 17;
		fold_neg = 1'b0;
		r_fold = r_raw;
		if (r_raw > HALF_PI_Q30) begin
			r_fold = r_raw - PI_Q30;
			fold_neg = 1'b1;
		end else if (r_raw < -HALF_PI_Q30) begin
			r_fold = r_raw + PI_Q30;
			fold_neg = 1'b1;
		end
		r_neg = r_fold[34];
		r_abs = r_neg ? 31'(-r_fold) : r_fold[30:0];
	end

	// shared multiplier
	always_comb begin
		mul_a = {1'b0, ar_q};
		mul_b = ar_q;
		if (state_q == SC_MUL) begin
			mul_a = r2_q;
			mul_b = t_q;
		end else if (state_q == SC_SIN_MUL) begin
			mul_b = t_q;
		end
		mul_p = 63'(mul_a) * 63'(mul_b);
	end

	erpt_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == SC_DIV_START),
		.dividend (num_q),
		.divisor  (horner_div(cos_q, step_q)),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign last_step = cos_q ? (step_q == 3'd6) : (step_q == 3'd5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SC_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SC_IDLE:      if (start) state_d = SC_SQUARE;
			SC_SQUARE:    state_d = SC_MUL;
			SC_MUL:       state_d = SC_DIV_START;
			SC_DIV_START: state_d = SC_DIV_WAIT;
			SC_DIV_WAIT: begin
				if (div_done) begin
					if (!last_step) state_d = SC_MUL;
					else if (!cos_q) state_d = SC_SIN_MUL;
					else state_d = SC_FINISH;
				end
			end
			SC_SIN_MUL:   state_d = SC_MUL;
			SC_FINISH:    state_d = SC_IDLE;
			default:      state_d = SC_IDLE;
		endcase
	end

	always_comb begin
		sm_rnd = {1'b0, sm_q} + 32'd8192;
		cm_rnd = {1'b0, t_q} + 32'd8192;
		sv_mag = sm_rnd[30:14];
		cv_mag = cm_rnd[30:14];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= (state_q == SC_FINISH);
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			SC_IDLE: begin
				ar_q <= r_abs;
				neg_q <= fold_neg;
				rneg_q <= r_neg;
			end
			SC_SQUARE: begin
				r2_q <= mul_p[61:30];
				t_q <= ONE_Q30;
				step_q <= '0;
				cos_q <= 1'b0;
			end
			SC_MUL: num_q <= mul_p[62:30];
			SC_DIV_START: ;
			SC_DIV_WAIT: begin
				if (div_done) begin
					t_q <= (div_quo > {2'b0, ONE_Q30}) ? '0 : 31'({2'b0, ONE_Q30} - div_quo);
					step_q <= step_q + 3'd1;
				end
			end
			SC_SIN_MUL: begin
				sm_q <= mul_p[60:30];
				t_q <= ONE_Q30;
				step_q <= '0;
				cos_q <= 1'b1;
			end
			SC_FINISH: begin
				sin_q <= (rneg_q != neg_q) ? -$signed({1'b0, sv_mag}) : $signed({1'b0, sv_mag});
				cos_val_q <= neg_q ? -$signed({1'b0, cv_mag}) : $signed({1'b0, cv_mag});
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign sin_val = sin_q;
	assign cos_val = cos_val_q;

endmodule

@@ rtl/erpt_rot.sv @@
// Angle registers and the sequencer that rebuilds the rotation matrix Rz*Ry*Rx.
module erpt_rot (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               angle_we,
	input  logic [1:0]         angle_sel,
	input  logic signed [15:0] angle_data,
	output logic               busy,
	output erpt_pkg::mat_t     mat
);
	import erpt_pkg::*;

	function automatic entry_t mq(entry_t a, entry_t b);
		logic signed [35:0] p;
		p = a * b + 36'sd32768;
		return p[33:16];
	endfunction

	function automatic entry_t sat18(logic signed [18:0] v);
		entry_t r;
		if (v > 19'sd131071) r = 18'sd131071;
		else if (v < -19'sd131072) r = -18'sd131072;
		else r = v[17:0];
		return r;
	endfunction

	rot_state_t state_q, state_d;

	logic signed [15:0] angle_q [3];
	entry_t             s_q [3];
	entry_t             c_q [3];
	entry_t             prod_q [NUM_PRODS];
	mat_t               mat_q;
	logic [1:0]         idx_q;
	logic [3:0]         pidx_q;

	logic   sc_done;
	entry_t sc_sin;
	entry_t sc_cos;
	entry_t opa;
	entry_t opb;

	erpt_sincos u_sincos (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (state_q == ROT_SC_START),
		.angle   (angle_q[idx_q]),
		.done    (sc_done),
		.sin_val (sc_sin),
		.cos_val (sc_cos)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ROT_IDLE;
			angle_q[0] <= '0;
			angle_q[1] <= '0;
			angle_q[2] <= '0;
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				mat_q[i] <= ((i % 4) == 0) ? ENTRY_ONE : '0;
			end
			idx_q <= '0;
			pidx_q <= '0;
		end else begin
			state_q <= state_d;
			if (angle_we && (angle_sel != 2'd3)) begin
				angle_q[angle_sel] <= angle_data;
			end
			if (state_q == ROT_IDLE) begin
				idx_q <= '0;
				pidx_q <= '0;
			end
			if ((state_q == ROT_SC_WAIT) && sc_done) begin
				idx_q <= idx_q + 2'd1;
			end
			if (state_q == ROT_PROD) begin
				pidx_q <= pidx_q + 4'd1;
			end
			if (state_q == ROT_COMBINE) begin
				mat_q[0] <= prod_q[2];
				mat_q[1] <= sat18(19'(prod_q[3]) - 19'(prod_q[4]));
				mat_q[2] <= sat18(19'(prod_q[5]) + 19'(prod_q[6]));
				mat_q[3] <= prod_q[7];
				mat_q[4] <= sat18(19'(prod_q[8]) + 19'(prod_q[9]));
				mat_q[5] <= sat18(19'(prod_q[10]) - 19'(prod_q[11]));
				mat_q[6] <= sat18(-19'(s_q[1]));
				mat_q[7] <= prod_q[12];
				mat_q[8] <= prod_q[13];
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ROT_IDLE:     if (angle_we && (angle_sel != 2'd3)) state_d = ROT_SC_START;
			ROT_SC_START: state_d = ROT_SC_WAIT;
			ROT_SC_WAIT: begin
				if (sc_done) state_d = (idx_q == 2'd2) ? ROT_PROD : ROT_SC_START;
			end
			ROT_PROD:     if (pidx_q == 4'(NUM_PRODS - 1)) state_d = ROT_COMBINE;
			ROT_COMBINE:  state_d = ROT_IDLE;
			default:      state_d = ROT_IDLE;
		endcase
	end

	// operand pair for each partial product of the matrix
	always_comb begin
		opa = s_q[0];
		opb = s_q[1];
		unique case (pidx_q)
			4'd0:  begin opa = s_q[0];    opb = s_q[1]; end
			4'd1:  begin opa = c_q[0];    opb = s_q[1]; end
			4'd2:  begin opa = c_q[1];    opb = c_q[2]; end
			4'd3:  begin opa = prod_q[0]; opb = c_q[2]; end
			4'd4:  begin opa = c_q[0];    opb = s_q[2]; end
			4'd5:  begin opa = s_q[0];    opb = s_q[2]; end
			4'd6:  begin opa = prod_q[1]; opb = c_q[2]; end
			4'd7:  begin opa = c_q[1];    opb = s_q[2]; end
			4'd8:  begin opa = c_q[0];    opb = c_q[2]; end
			4'd9:  begin opa = prod_q[0]; opb = s_q[2]; end
			4'd10: begin opa = prod_q[1]; opb = s_q[2]; end
			4'd11: begin opa = s_q[0];    opb = c_q[2]; end
			4'd12: begin opa = s_q[0];    opb = c_q[1]; end
			4'd13: begin opa = c_q[0];    opb = c_q[1]; end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if ((state_q == ROT_SC_WAIT) && sc_done && (idx_q != 2'd3)) begin
			s_q[idx_q] <= sc_sin;
			c_q[idx_q] <= sc_cos;
		end
		if ((state_q == ROT_PROD) && (pidx_q < 4'(NUM_PRODS))) begin
			prod_q[pidx_q] <= mq(opa, opb);
		end
	end

	assign busy = (state_q != ROT_IDLE);
	assign mat = mat_q;

endmodule

@@ rtl/erpt_point.sv @@
// Four-stage point pipeline: input register, products, row sums, round/shift/saturate.
module erpt_point (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] in_x,
	input  logic signed [31:0] in_y,
	input  logic signed [31:0] in_z,
	input  logic               in_last,
	input  erpt_pkg::mat_t     mat,
	input  logic signed [31:0] shift_x,
	input  logic signed [31:0] shift_y,
	input  logic signed [31:0] shift_z,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [95:0]        out_data,
	output logic               out_last
);
	import erpt_pkg::*;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               adv1, adv2, adv3, adv4;
	logic signed [31:0] p_s1 [3];
	logic               last_s1, last_s2, last_s3, last_s4;
	logic signed [49:0] prod_s2 [NUM_ENTRIES];
	logic signed [51:0] sum_s3 [3];
	logic signed [31:0] res_s4 [3];
	logic signed [31:0] shift [3];
	logic signed [31:0] res_d [3];

	assign adv4 = !v_s4 || out_ready;
	assign adv3 = !v_s3 || adv4;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	assign shift[0] = shift_x;
	assign shift[1] = shift_y;
	assign shift[2] = shift_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
			if (adv3) v_s3 <= v_s2;
			if (adv4) v_s4 <= v_s3;
		end
	end

	// round to Q16.16, add the translation, clamp to the coordinate range
	always_comb begin
		logic signed [35:0] rnd;
		logic signed [36:0] tot;
		for (int r = 0; r < 3; r++) begin
			rnd = 36'((sum_s3[r] + 52'sd32768) >>> 16);
			tot = 37'(rnd) + 37'(shift[r]);
			if (tot > 37'sd2147483647) res_d[r] = 32'sh7fff_ffff;
			else if (tot < -37'sd2147483648) res_d[r] = 32'sh8000_0000;
			else res_d[r] = tot[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			p_s1[0] <= in_x;
			p_s1[1] <= in_y;
			p_s1[2] <= in_z;
			last_s1 <= in_last;
		end
		if (adv2 && v_s1) begin
			for (int i = 0; i < NUM_ENTRIES; i++) begin
				prod_s2[i] <= 50'($signed(mat[i])) * 50'(p_s1[i % 3]);
			end
			last_s2 <= last_s1;
		end
		if (adv3 && v_s2) begin
			for (int r = 0; r < 3; r++) begin
				sum_s3[r] <= 52'(prod_s2[3 * r]) + 52'(prod_s2[3 * r + 1])
					+ 52'(prod_s2[3 * r + 2]);
			end
			last_s3 <= last_s2;
		end
		if (adv4 && v_s3) begin
			res_s4[0] <= res_d[0];
			res_s4[1] <= res_d[1];
			res_s4[2] <= res_d[2];
			last_s4 <= last_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_data = {res_s4[2], res_s4[1], res_s4[0]};
	assign out_last = last_s4;

endmodule

@@ rtl/euler_rigid_point_transform.sv @@
// Top level: rigid motion R*p + t of a 3-D point stream, R = Rz*Ry*Rx from three angles.
//
// Usage:
//   Points enter on the s_axis channel, one request per point (x, y, z in Q16.16),
//   with tlast marking the final point of a frame. Each point gives exactly one
//   result on m_axis: the rotated, translated and saturated coordinates, tlast copied.
//   The cfg channel writes angle_x/y/z (Q2.13 radians, index 0..2) and
//   shift_x/y/z (Q16.16, index 3..5); other indexes are dropped.
// Timing:
//   One point per cycle is taken sustained while the receiver keeps up and no rebuild
//   runs; the pipeline has four registered stages with per-stage valid,
//   so bubbles close up while the receiver stalls and inputs stall only once all
//   four stages hold results.
//   An angle write starts a rebuild of the matrix: three sine/cosine runs, each a
//   Horner series of 13 multiply/divide steps (the divide is a reciprocal
//   multiplication), then 14 sequenced matrix products.
//   During a rebuild s_axis_tready and cfg_ready stay low.
//   Shift writes take effect with no rebuild, also on points still in the pipeline.
// Reset:
//   arst_n clears the pipeline, zeroes angles and shifts and loads the identity.
module euler_rigid_point_transform (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,   // point_x [31:0], point_y [63:32], point_z [95:64]
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,   // moved_x [31:0], moved_y [63:32], moved_z [95:64]
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import erpt_pkg::*;

	logic               busy;
	logic               cfg_fire;
	logic               angle_we;
	logic               pt_ready;
	mat_t               mat;
	logic signed [31:0] shift_x_q, shift_y_q, shift_z_q;

	// hold off both requests while the matrix rebuild runs
	assign cfg_ready = !busy;
	assign cfg_fire = cfg_valid && cfg_ready;
	assign angle_we = cfg_fire && ((cfg_index == REG_ANGLE_X) || (cfg_index == REG_ANGLE_Y)
		|| (cfg_index == REG_ANGLE_Z));
	assign s_axis_tready = pt_ready && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_x_q <= '0;
			shift_y_q <= '0;
			shift_z_q <= '0;
		end else if (cfg_fire) begin
			if (cfg_index == REG_SHIFT_X) shift_x_q <= cfg_data;
			if (cfg_index == REG_SHIFT_Y) shift_y_q <= cfg_data;
			if (cfg_index == REG_SHIFT_Z) shift_z_q <= cfg_data;
		end
	end

	erpt_rot u_rot (
		.clk        (clk),
		.arst_n     (arst_n),
		.angle_we   (angle_we),
		.angle_sel  (cfg_index[1:0]),
		.angle_data (cfg_data[15:0]),
		.busy       (busy),
		.mat        (mat)
	);

	erpt_point u_point (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid && !busy),
		.in_ready  (pt_ready),
		.in_x      (s_axis_tdata[31:0]),
		.in_y      (s_axis_tdata[63:32]),
		.in_z      (s_axis_tdata[95:64]),
		.in_last   (s_axis_tlast),
		.mat       (mat),
		.shift_x   (shift_x_q),
		.shift_y   (shift_y_q),
		.shift_z   (shift_z_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> (!s_axis_tready && !cfg_ready))
		else $error("request accepted during matrix rebuild");

	a_angle_starts: assert property (@(posedge clk) disable iff (!arst_n)
		angle_we |=> busy)
		else $error("angle write did not start a rebuild");

	a_shift_no_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_fire && ((cfg_index == REG_SHIFT_X) || (cfg_index == REG_SHIFT_Y)
		|| (cfg_index == REG_SHIFT_Z))) |=> !busy)
		else $error("shift write started a rebuild");

endmodule
